[rtl/core/mrdec_pkg.sv]
// Package with the mnemonic codes, operand kinds and decode result type of the decoder.
`default_nettype none

package mrdec_pkg;

  localparam int unsigned InstrW = 14;
  localparam int unsigned BankW  = 9;
  localparam int unsigned MnW    = 6;
  localparam int unsigned KindW  = 3;
  localparam int unsigned FaW    = 9;
  localparam int unsigned BitW   = 3;
  localparam int unsigned LitW   = 11;

  // Mnemonic codes.
  localparam logic [MnW-1:0] MN_NOP          = 6'd0;
  localparam logic [MnW-1:0] MN_RESET        = 6'd1;
  localparam logic [MnW-1:0] MN_RETURN       = 6'd2;
  localparam logic [MnW-1:0] MN_RETFIE       = 6'd3;
  localparam logic [MnW-1:0] MN_CALLW        = 6'd4;
  localparam logic [MnW-1:0] MN_BRW          = 6'd5;
  localparam logic [MnW-1:0] MN_OPTION       = 6'd6;
  localparam logic [MnW-1:0] MN_SLEEP        = 6'd7;
  localparam logic [MnW-1:0] MN_CLRWDT       = 6'd8;
  localparam logic [MnW-1:0] MN_TRISA        = 6'd9;
  localparam logic [MnW-1:0] MN_TRISB        = 6'd10;
  localparam logic [MnW-1:0] MN_TRISC        = 6'd11;
  localparam logic [MnW-1:0] MN_MOVWF        = 6'd12;
  localparam logic [MnW-1:0] MN_CLRF         = 6'd13;
  localparam logic [MnW-1:0] MN_CLRW         = 6'd14;
  localparam logic [MnW-1:0] MN_BYTE_BASE    = 6'd13;
  localparam logic [MnW-1:0] MN_BYTE_UNKNOWN = 6'd29;
  localparam logic [MnW-1:0] MN_BIT_BASE     = 6'd26;
  localparam logic [MnW-1:0] MN_CALL         = 6'd34;
  localparam logic [MnW-1:0] MN_GOTO         = 6'd35;
  localparam logic [MnW-1:0] MN_MOVLW        = 6'd36;
  localparam logic [MnW-1:0] MN_RETLW        = 6'd37;
  localparam logic [MnW-1:0] MN_SUBLW        = 6'd38;
  localparam logic [MnW-1:0] MN_ADDLW        = 6'd39;
  localparam logic [MnW-1:0] MN_IORLW        = 6'd40;
  localparam logic [MnW-1:0] MN_ANDLW        = 6'd41;
  localparam logic [MnW-1:0] MN_XORLW        = 6'd42;
  localparam logic [MnW-1:0] MN_UNKNOWN      = 6'd43;

  // Operand kinds.
  localparam logic [KindW-1:0] KIND_NONE      = 3'd0;
  localparam logic [KindW-1:0] KIND_FILE      = 3'd1;
  localparam logic [KindW-1:0] KIND_FILE_DEST = 3'd2;
  localparam logic [KindW-1:0] KIND_FILE_BIT  = 3'd3;
  localparam logic [KindW-1:0] KIND_TARGET    = 3'd4;
  localparam logic [KindW-1:0] KIND_LITERAL   = 3'd5;

  typedef struct packed {
    logic [MnW-1:0]   mnemonic;
    logic [KindW-1:0] operand_kind;
    logic [FaW-1:0]   file_address;
    logic             dest_is_file;
    logic [BitW-1:0]  bit_number;
    logic [LitW-1:0]  literal_or_target;
  } dec_result_t;

endpackage

`default_nettype wire

[rtl/core/midrange_instruction_decoder.sv]
// Top level of the midrange instruction decoder: input register, decode, result register.
`default_nettype none

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  instruction[13:0], bank_base[8:0]
// out_     output     out_valid/out_stall mnemonic, operand_kind, file_address,
//                                        dest_is_file, bit_number, literal_or_target
//
// Each word is held in the input register, decoded combinationally, and then held in the
// result register, which drives the outputs. One word is accepted every cycle while the
// result side does not stall. Reset (synchronous, rst_n low) clears both valid flags;
// the payload registers are not reset. A stall on the result side holds the result
// register and backs up into the input register, which keeps taking words until it is
// full as well.

module midrange_instruction_decoder
  import mrdec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [InstrW-1:0] in_instruction,
  input  wire logic [BankW-1:0]  in_bank_base,

  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [MnW-1:0]    out_mnemonic,
  output      logic [KindW-1:0]  out_operand_kind,
  output      logic [FaW-1:0]    out_file_address,
  output      logic              out_dest_is_file,
  output      logic [BitW-1:0]   out_bit_number,
  output      logic [LitW-1:0]   out_literal_or_target
);

  // Input register stage.
  logic              s1_valid_r;
  logic [InstrW-1:0] s1_instr_r;
  logic [BankW-1:0]  s1_bank_r;

  // Result register stage.
  logic              out_valid_r;
  dec_result_t       out_res_r;
  dec_result_t       dec_res;

  logic out_en;
  logic s1_en;

  // The result register loads when it is empty or its word is being taken.
  // The input register loads when it is empty or its word moves on.
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;

  mrdec_decode u_decode (
    .instruction (s1_instr_r),
    .bank_base   (s1_bank_r),
    .result      (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (out_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers follow the same enables and need no reset.
  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_instr_r <= in_instruction;
      s1_bank_r  <= in_bank_base;
    end
    if (out_en && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mnemonic          = out_res_r.mnemonic;
  assign out_operand_kind      = out_res_r.operand_kind;
  assign out_file_address      = out_res_r.file_address;
  assign out_dest_is_file      = out_res_r.dest_is_file;
  assign out_bit_number        = out_res_r.bit_number;
  assign out_literal_or_target = out_res_r.literal_or_target;

endmodule

`default_nettype wire

[rtl/core/mrdec_decode.sv]
// Combinational decode of one 14-bit instruction word into mnemonic and operand fields.
`default_nettype none

module mrdec_decode
  import mrdec_pkg::*;
(
  input  wire logic [InstrW-1:0] instruction,
  input  wire logic [BankW-1:0]  bank_base,
  output dec_result_t            result
);

  localparam logic [InstrW-1:0] NOP_MASK = 14'h3F9F;
  localparam logic [InstrW-1:0] W_RESET  = 14'h0001;
  localparam logic [InstrW-1:0] W_RETURN = 14'h0008;
  localparam logic [InstrW-1:0] W_RETFIE = 14'h0009;
  localparam logic [InstrW-1:0] W_CALLW  = 14'h000A;
  localparam logic [InstrW-1:0] W_BRW    = 14'h000B;
  localparam logic [InstrW-1:0] W_OPTION = 14'h0062;
  localparam logic [InstrW-1:0] W_SLEEP  = 14'h0063;
  localparam logic [InstrW-1:0] W_CLRWDT = 14'h0064;
  localparam logic [InstrW-1:0] W_TRISA  = 14'h0065;
  localparam logic [InstrW-1:0] W_TRISB  = 14'h0066;
  localparam logic [InstrW-1:0] W_TRISC  = 14'h0067;

  localparam logic [1:0] GRP_BYTE = 2'd0;
  localparam logic [1:0] GRP_BIT  = 2'd1;
  localparam logic [1:0] GRP_JUMP = 2'd2;

  logic [FaW-1:0] faddr;
  logic [3:0]     byte_op;
  logic           d7;

  assign faddr   = bank_base + {2'b00, instruction[6:0]};
  assign byte_op = instruction[11:8];
  assign d7      = instruction[7];

  always_comb begin
    result = '0;
    result.mnemonic = MN_UNKNOWN;
    if ((instruction & NOP_MASK) == '0) begin
      result.mnemonic = MN_NOP;
    end else if (instruction == W_RESET) begin
      result.mnemonic = MN_RESET;
    end else if (instruction == W_RETURN) begin
      result.mnemonic = MN_RETURN;
    end else if (instruction == W_RETFIE) begin
      result.mnemonic = MN_RETFIE;
    end else if (instruction == W_CALLW) begin
      result.mnemonic = MN_CALLW;
    end else if (instruction == W_BRW) begin
      result.mnemonic = MN_BRW;
    end else if (instruction == W_OPTION) begin
      result.mnemonic = MN_OPTION;
    end else if (instruction == W_SLEEP) begin
      result.mnemonic = MN_SLEEP;
    end else if (instruction == W_CLRWDT) begin
      result.mnemonic = MN_CLRWDT;
    end else if (instruction == W_TRISA) begin
      result.mnemonic = MN_TRISA;
    end else if (instruction == W_TRISB) begin
      result.mnemonic = MN_TRISB;
    end else if (instruction == W_TRISC) begin
      result.mnemonic = MN_TRISC;
    end else if (instruction[13:12] == GRP_BYTE) begin
      if (byte_op == 4'd0 && d7) begin
        result.mnemonic     = MN_MOVWF;
        result.operand_kind = KIND_FILE;
        result.file_address = faddr;
      end else if (byte_op == 4'd1) begin
        if (d7) begin
          result.mnemonic     = MN_CLRF;
          result.operand_kind = KIND_FILE;
          result.file_address = faddr;
        end else begin
          result.mnemonic = MN_CLRW;
        end
      end else begin
        // Opcode zero without the destination bit has no mnemonic of its own.
        result.mnemonic     = (byte_op == 4'd0) ? MN_BYTE_UNKNOWN
                                                : MN_BYTE_BASE + {2'b00, byte_op};
        result.operand_kind = KIND_FILE_DEST;
        result.file_address = faddr;
        result.dest_is_file = d7;
      end
    end else if (instruction[13:12] == GRP_BIT) begin
      result.mnemonic     = MN_BIT_BASE + {2'b00, instruction[13:10]};
      result.operand_kind = KIND_FILE_BIT;
      result.file_address = faddr;
      result.bit_number   = instruction[9:7];
    end else if (instruction[13:12] == GRP_JUMP) begin
      result.mnemonic          = instruction[11] ? MN_GOTO : MN_CALL;
      result.operand_kind      = KIND_TARGET;
      result.literal_or_target = instruction[10:0];
    end else begin
      result.operand_kind      = KIND_LITERAL;
      result.literal_or_target = {3'b000, instruction[7:0]};
      case (instruction[11:8])
        4'h0, 4'h1, 4'h2, 4'h3: result.mnemonic = MN_MOVLW;
        4'h4, 4'h5, 4'h6, 4'h7: result.mnemonic = MN_RETLW;
        4'hC, 4'hD:             result.mnemonic = MN_SUBLW;
        4'hE, 4'hF:             result.mnemonic = MN_ADDLW;
        4'h8:                   result.mnemonic = MN_IORLW;
        4'h9:                   result.mnemonic = MN_ANDLW;
        4'hA:                   result.mnemonic = MN_XORLW;
        default: begin
          result.mnemonic          = MN_UNKNOWN;
          result.operand_kind      = KIND_NONE;
          result.literal_or_target = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
